// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and helpers for the playback transport controller
// Frame width, operation and state codes, the transport state record and
// the timeline seek rule used by seeks, steps and rewinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int FrameBits = 24;
  localparam int WideBits  = FrameBits + 2;

  typedef logic [FrameBits-1:0]       frame_t;
  typedef logic signed [WideBits-1:0] wide_t;

  typedef enum logic [2:0] {
    OpTick     = 3'd0,
    OpSetPlay  = 3'd1,
    OpSeek     = 3'd2,
    OpAction   = 3'd3,
    OpInHere   = 3'd4,
    OpOutHere  = 3'd5,
    OpResetIn  = 3'd6,
    OpResetOut = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ActGoIn    = 3'd0,
    ActGoOut   = 3'd1,
    ActBack1   = 3'd2,
    ActBack10  = 3'd3,
    ActBack100 = 3'd4,
    ActFwd1    = 3'd5,
    ActFwd10   = 3'd6,
    ActFwd100  = 3'd7
  } action_e;

  // play state codes
  localparam logic [1:0] PlayStop = 2'd0;
  localparam logic [1:0] PlayFwd  = 2'd1;
  localparam logic [1:0] PlayRev  = 2'd2;

  // loop mode codes
  localparam logic [1:0] ModeLoop     = 2'd0;
  localparam logic [1:0] ModeOnce     = 2'd1;
  localparam logic [1:0] ModePingPong = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgLoopMode = 2'd0;
  localparam logic [1:0] CfgTlStart  = 2'd1;
  localparam logic [1:0] CfgTlEnd    = 2'd2;

  typedef struct packed {
    frame_t     frame;
    logic [1:0] play;
    frame_t     first;
    frame_t     last;
  } xport_t;

  typedef struct packed {
    logic [1:0] loop_mode;
    frame_t     tl_start;
    frame_t     tl_end;
  } cfg_t;

  function automatic wide_t widen(input frame_t f);
    return $signed({2'b00, f});
  endfunction

  // targets off either end of the timeline wrap to the opposite end
  function automatic frame_t seek_to(input wide_t target, input frame_t ts,
                                     input frame_t te);
    frame_t res;
    if (target < widen(ts)) begin
      res = te;
    end else if (target > widen(te)) begin
      res = ts;
    end else begin
      res = target[FrameBits-1:0];
    end
    return res;
  endfunction

  function automatic wide_t step_size(input action_e act);
    wide_t res;
    case (act)
      ActBack1, ActFwd1:     res = wide_t'(1);
      ActBack10, ActFwd10:   res = wide_t'(10);
      ActBack100, ActFwd100: res = wide_t'(100);
      default:               res = wide_t'(0);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ptc_next.sv -----
// ----------------------------------------------------------------------------
// ptc_next: next transport state for one request
// Combinational update of frame, play state and in/out range from the
// current state, the configuration and one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_next (
  input  ptc_pkg::xport_t st_i,
  input  ptc_pkg::cfg_t   cfg_i,
  input  logic [2:0]      opcode_i,
  input  logic [1:0]      playback_request_i,
  input  ptc_pkg::frame_t target_frame_i,
  input  logic [2:0]      action_i,
  output ptc_pkg::xport_t nxt_o
);

  logic [1:0]       mode;
  logic [1:0]       req;
  logic             playing;
  ptc_pkg::wide_t   pos_w;
  ptc_pkg::wide_t   t;
  ptc_pkg::wide_t   lo;
  ptc_pkg::wide_t   hi;
  ptc_pkg::frame_t  step_frame;
  ptc_pkg::action_e act;

  assign mode = (cfg_i.loop_mode == ptc_pkg::ModeOnce ||
                 cfg_i.loop_mode == ptc_pkg::ModePingPong) ?
                cfg_i.loop_mode : ptc_pkg::ModeLoop;
  assign req  = (playback_request_i == ptc_pkg::PlayFwd ||
                 playback_request_i == ptc_pkg::PlayRev) ?
                playback_request_i : ptc_pkg::PlayStop;
  assign playing = (st_i.play == ptc_pkg::PlayFwd) || (st_i.play == ptc_pkg::PlayRev);
  assign pos_w   = ptc_pkg::widen(st_i.frame);
  assign lo      = ptc_pkg::widen(st_i.first);
  assign hi      = ptc_pkg::widen(st_i.last);
  assign t       = pos_w + ((st_i.play == ptc_pkg::PlayFwd) ?
                            ptc_pkg::wide_t'(1) : ptc_pkg::wide_t'(-1));
  assign act     = ptc_pkg::action_e'(action_i);

  // frame steps from the time actions
  always_comb begin
    case (act)
      ptc_pkg::ActGoIn:
        step_frame = ptc_pkg::seek_to(lo, cfg_i.tl_start, cfg_i.tl_end);
      ptc_pkg::ActGoOut:
        step_frame = ptc_pkg::seek_to(hi, cfg_i.tl_start, cfg_i.tl_end);
      ptc_pkg::ActBack1, ptc_pkg::ActBack10, ptc_pkg::ActBack100:
        step_frame = ptc_pkg::seek_to(pos_w - ptc_pkg::step_size(act),
                                      cfg_i.tl_start, cfg_i.tl_end);
      default:
        step_frame = ptc_pkg::seek_to(pos_w + ptc_pkg::step_size(act),
                                      cfg_i.tl_start, cfg_i.tl_end);
    endcase
  end

  always_comb begin
    nxt_o = st_i;
    case (ptc_pkg::opcode_e'(opcode_i))
      ptc_pkg::OpTick: begin
        if (playing) begin
          nxt_o.frame = t[ptc_pkg::FrameBits-1:0];
          if (mode == ptc_pkg::ModeOnce) begin
            if (t < lo) begin
              nxt_o.frame = st_i.first;
              nxt_o.play  = ptc_pkg::PlayStop;
            end else if (t > hi) begin
              nxt_o.frame = st_i.last;
              nxt_o.play  = ptc_pkg::PlayStop;
            end
          end else if (mode == ptc_pkg::ModePingPong) begin
            if (t < lo && st_i.play == ptc_pkg::PlayRev) begin
              nxt_o.frame = st_i.first;
              nxt_o.play  = ptc_pkg::PlayFwd;
            end else if (t > hi && st_i.play == ptc_pkg::PlayFwd) begin
              nxt_o.frame = st_i.last;
              nxt_o.play  = ptc_pkg::PlayRev;
            end
          end else begin
            if (t < lo) begin
              nxt_o.frame = st_i.last;
            end else if (t > hi) begin
              nxt_o.frame = st_i.first;
            end
          end
        end
      end
      ptc_pkg::OpSetPlay: begin
        nxt_o.play = req;
        if (mode == ptc_pkg::ModeOnce) begin
          if (req == ptc_pkg::PlayFwd && st_i.frame == st_i.last) begin
            nxt_o.frame = ptc_pkg::seek_to(lo, cfg_i.tl_start, cfg_i.tl_end);
          end else if (req == ptc_pkg::PlayRev && st_i.frame == st_i.first) begin
            nxt_o.frame = ptc_pkg::seek_to(hi, cfg_i.tl_start, cfg_i.tl_end);
          end
        end else if (mode == ptc_pkg::ModePingPong) begin
          if (req == ptc_pkg::PlayFwd && st_i.frame == st_i.last) begin
            nxt_o.play = ptc_pkg::PlayRev;
          end else if (req == ptc_pkg::PlayRev && st_i.frame == st_i.first) begin
            nxt_o.play = ptc_pkg::PlayFwd;
          end
        end
      end
      ptc_pkg::OpSeek: begin
        nxt_o.frame = ptc_pkg::seek_to(ptc_pkg::widen(target_frame_i),
                                       cfg_i.tl_start, cfg_i.tl_end);
      end
      ptc_pkg::OpAction: begin
        nxt_o.play  = ptc_pkg::PlayStop;
        nxt_o.frame = step_frame;
      end
      ptc_pkg::OpInHere:   nxt_o.first = st_i.frame;
      ptc_pkg::OpOutHere:  nxt_o.last  = st_i.frame;
      ptc_pkg::OpResetIn:  nxt_o.first = cfg_i.tl_start;
      ptc_pkg::OpResetOut: nxt_o.last  = cfg_i.tl_end;
      default:             nxt_o = st_i;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/playback_transport_controller_top.sv -----
// ----------------------------------------------------------------------------
// playback_transport_controller_top: frame-position transport controller
// Keeps the current frame, play state and in/out range of a timeline.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_* valid/ready channel; each one produces
//   exactly one result on the out_* channel: frame, play state, in point
//   and out point after the request.
//   The result is registered: a request accepted at an edge shows its result
//   valid from that edge on. Throughput is one request per cycle while the
//   receiver takes results; the whole update is one pass of compare/add
//   logic into the state registers, which double as the result register.
//   When the receiver stalls, the held result blocks the next request;
//   in_ready_o follows out_ready_i in the same cycle, so a result taken
//   in a cycle frees room for a new request in that cycle.
//   The user writes configuration (loop mode, timeline start and end) through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; not enforced by the block.
//   Reset clears frame, play state and range to zero, loop mode to wrap,
//   timeline start to zero and timeline end to all ones; no result is
//   pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module playback_transport_controller_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  ptc_pkg::frame_t       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            opcode_i,
  input  logic [1:0]            playback_request_i,
  input  ptc_pkg::frame_t       target_frame_i,
  input  logic [2:0]            action_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ptc_pkg::frame_t       current_frame_o,
  output logic [1:0]            playback_state_o,
  output ptc_pkg::frame_t       in_point_o,
  output ptc_pkg::frame_t       out_point_o
);

  ptc_pkg::cfg_t   cfg_q;
  ptc_pkg::xport_t st_q;
  ptc_pkg::xport_t st_d;
  logic            valid_q;
  logic            accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ptc_next u_next (
    .st_i               (st_q),
    .cfg_i              (cfg_q),
    .opcode_i           (opcode_i),
    .playback_request_i (playback_request_i),
    .target_frame_i     (target_frame_i),
    .action_i           (action_i),
    .nxt_o              (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_mode <= ptc_pkg::ModeLoop;
      cfg_q.tl_start  <= '0;
      cfg_q.tl_end    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptc_pkg::CfgLoopMode: cfg_q.loop_mode <= cfg_wdata_i[1:0];
        ptc_pkg::CfgTlStart:  cfg_q.tl_start  <= cfg_wdata_i;
        ptc_pkg::CfgTlEnd:    cfg_q.tl_end    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign current_frame_o  = st_q.frame;
  assign playback_state_o = st_q.play;
  assign in_point_o       = st_q.first;
  assign out_point_o      = st_q.last;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for playback_transport_controller_top
// A queue of requests feeds a clocked driver, and a clocked monitor checks
// every result against a transport model kept in step with accepted
// requests. Phases change loop mode and timeline between runs: a directed
// opening, then range/play/tick sequences mixed with random requests, with
// random idle bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ptc_pkg::*;

  localparam int           CycleLimit = 200000;
  localparam frame_t       FrameMax   = '1;
  localparam logic [1:0]   ModeAlias  = 2'd3;  // unused mode code, acts as wrap
  localparam logic [1:0]   PlayAlias  = 2'd3;  // unused play code, acts as stop

  typedef struct packed {
    opcode_e    op;
    logic [1:0] play_req;
    frame_t     target;
    action_e    act;
  } transport_req_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CfgLoopMode;
  frame_t     cfg_wdata_i = '0;
  logic       in_valid_i  = 1'b0;
  logic [2:0] opcode_i    = OpTick;
  logic [1:0] playback_request_i = PlayStop;
  frame_t     target_frame_i     = '0;
  logic [2:0] action_i    = ActGoIn;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  frame_t     current_frame_o;
  logic [1:0] playback_state_o;
  frame_t     in_point_o;
  frame_t     out_point_o;

  playback_transport_controller_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .playback_request_i (playback_request_i),
    .target_frame_i     (target_frame_i),
    .action_i           (action_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .current_frame_o    (current_frame_o),
    .playback_state_o   (playback_state_o),
    .in_point_o         (in_point_o),
    .out_point_o        (out_point_o)
  );

  transport_req_t pending_reqs[$];
  xport_t         expected_states[$];
  transport_req_t drive_req;
  xport_t         xport_state;
  cfg_t           cfg_state;
  int             queued_total = 0;
  int             mismatches   = 0;
  int             result_count = 0;
  int             cycle_count  = 0;
  int             gap_left     = 0;
  int             stall_left   = 0;
  int             in_idle_pct  = 0;
  int             out_idle_pct = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("playback_transport_controller_top regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  // seeks and steps leaving the timeline land on the opposite end
  function automatic frame_t timeline_wrap(input int target);
    frame_t res;
    if (target < int'(cfg_state.tl_start)) begin
      res = cfg_state.tl_end;
    end else if (target > int'(cfg_state.tl_end)) begin
      res = cfg_state.tl_start;
    end else begin
      res = frame_t'(target);
    end
    return res;
  endfunction

  function automatic int step_frames(input action_e act);
    int res;
    case (act)
      ActBack1, ActFwd1:   res = 1;
      ActBack10, ActFwd10: res = 10;
      default:             res = 100;
    endcase
    return res;
  endfunction

  function automatic xport_t apply_transport(input transport_req_t r);
    int         t;
    int         lo;
    int         hi;
    logic [1:0] mode;
    logic [1:0] want;
    mode = (cfg_state.loop_mode == ModeOnce || cfg_state.loop_mode == ModePingPong) ?
           cfg_state.loop_mode : ModeLoop;
    lo = int'(xport_state.first);
    hi = int'(xport_state.last);
    case (r.op)
      OpTick: begin
        if (xport_state.play == PlayFwd || xport_state.play == PlayRev) begin
          t = int'(xport_state.frame) + ((xport_state.play == PlayFwd) ? 1 : -1);
          if (mode == ModeLoop) begin
            if (t < lo) t = hi;
            else if (t > hi) t = lo;
          end else if (mode == ModeOnce) begin
            if (t < lo) begin
              t = lo;
              xport_state.play = PlayStop;
            end else if (t > hi) begin
              t = hi;
              xport_state.play = PlayStop;
            end
          end else begin
            if (t < lo && xport_state.play == PlayRev) begin
              t = lo;
              xport_state.play = PlayFwd;
            end else if (t > hi && xport_state.play == PlayFwd) begin
              t = hi;
              xport_state.play = PlayRev;
            end
          end
          xport_state.frame = frame_t'(t);
        end
      end
      OpSetPlay: begin
        want = (r.play_req == PlayFwd || r.play_req == PlayRev) ? r.play_req : PlayStop;
        if (mode == ModeOnce) begin
          if (want == PlayFwd && xport_state.frame == xport_state.last) begin
            xport_state.frame = timeline_wrap(lo);
          end else if (want == PlayRev && xport_state.frame == xport_state.first) begin
            xport_state.frame = timeline_wrap(hi);
          end
        end else if (mode == ModePingPong) begin
          if (want == PlayFwd && xport_state.frame == xport_state.last) begin
            want = PlayRev;
          end else if (want == PlayRev && xport_state.frame == xport_state.first) begin
            want = PlayFwd;
          end
        end
        xport_state.play = want;
      end
      OpSeek: xport_state.frame = timeline_wrap(int'(r.target));
      OpAction: begin
        xport_state.play = PlayStop;
        case (r.act)
          ActGoIn:  xport_state.frame = timeline_wrap(lo);
          ActGoOut: xport_state.frame = timeline_wrap(hi);
          ActBack1, ActBack10, ActBack100: begin
            xport_state.frame = timeline_wrap(int'(xport_state.frame) - step_frames(r.act));
          end
          default: begin
            xport_state.frame = timeline_wrap(int'(xport_state.frame) + step_frames(r.act));
          end
        endcase
      end
      OpInHere:   xport_state.first = xport_state.frame;
      OpOutHere:  xport_state.last  = xport_state.frame;
      OpResetIn:  xport_state.first = cfg_state.tl_start;
      default:    xport_state.last  = cfg_state.tl_end;
    endcase
    return xport_state;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_states = {expected_states, apply_transport(drive_req)};
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) < in_idle_pct) begin
          gap_left = $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drive_req = pending_reqs.pop_front();
          in_valid_i         <= 1'b1;
          opcode_i           <= drive_req.op;
          playback_request_i <= drive_req.play_req;
          target_frame_i     <= drive_req.target;
          action_i           <= drive_req.act;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    xport_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_states.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_count));
        end else begin
          want = expected_states.pop_front();
          if (current_frame_o !== want.frame)
            report_mismatch($sformatf("result %0d current_frame %h, want %h",
                                      result_count, current_frame_o, want.frame));
          if (playback_state_o !== want.play)
            report_mismatch($sformatf("result %0d playback_state %0d, want %0d",
                                      result_count, playback_state_o, want.play));
          if (in_point_o !== want.first)
            report_mismatch($sformatf("result %0d in_point %h, want %h",
                                      result_count, in_point_o, want.first));
          if (out_point_o !== want.last)
            report_mismatch($sformatf("result %0d out_point %h, want %h",
                                      result_count, out_point_o, want.last));
        end
        result_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input frame_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgLoopMode: cfg_state.loop_mode = val[1:0];
      CfgTlStart:  cfg_state.tl_start  = val;
      default:     cfg_state.tl_end    = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_states.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic queue_req(input opcode_e op, input logic [1:0] play_req,
                           input frame_t target, input action_e act);
    transport_req_t r;
    r.op       = op;
    r.play_req = play_req;
    r.target   = target;
    r.act      = act;
    pending_reqs = {pending_reqs, r};
    queued_total++;
  endtask

  function automatic logic [1:0] rnd_play();
    logic [1:0] res;
    case ($urandom_range(0, 7))
      0, 1, 2: res = PlayFwd;
      3, 4, 5: res = PlayRev;
      6:       res = PlayStop;
      default: res = PlayAlias;
    endcase
    return res;
  endfunction

  function automatic action_e rnd_act();
    return action_e'($urandom_range(0, 7));
  endfunction

  // frames near the timeline, or near its start, the frame extremes or anywhere
  function automatic frame_t pick_target();
    int     lo;
    int     hi;
    int     v;
    frame_t res;
    lo = (cfg_state.tl_start < cfg_state.tl_end) ? int'(cfg_state.tl_start) :
                                                   int'(cfg_state.tl_end);
    hi = (cfg_state.tl_start < cfg_state.tl_end) ? int'(cfg_state.tl_end) :
                                                   int'(cfg_state.tl_start);
    if (hi - lo < 1000) begin
      v = lo - 3 + $urandom_range(0, hi - lo + 6);
    end else begin
      case ($urandom_range(0, 3))
        0:       v = $urandom_range(0, 40);
        1:       v = int'(FrameMax) - $urandom_range(0, 40);
        2:       v = lo + $urandom_range(0, 40) - 20;
        default: v = $urandom_range(0, int'(FrameMax));
      endcase
    end
    if (v < 0) v = 0;
    else if (v > int'(FrameMax)) v = int'(FrameMax);
    res = frame_t'(v);
    return res;
  endfunction

  task automatic queue_noise();
    queue_req(opcode_e'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
              ($urandom_range(0, 3) == 0) ? frame_t'($urandom) : pick_target(), rnd_act());
  endtask

  // mostly: set a range, park in or just outside it, start play, tick through
  task automatic queue_random_phase(input int goal);
    int     stop_at;
    frame_t a;
    frame_t b;
    stop_at = queued_total + goal;
    while (queued_total < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        a = pick_target();
        b = a + frame_t'($urandom_range(0, 12));
        if ($urandom_range(0, 7) == 0) {a, b} = {b, a};
        queue_req(OpSeek, rnd_play(), a, rnd_act());
        queue_req(OpInHere, rnd_play(), frame_t'($urandom), rnd_act());
        queue_req(OpSeek, rnd_play(), b, rnd_act());
        queue_req(OpOutHere, rnd_play(), frame_t'($urandom), rnd_act());
        queue_req(OpSeek, rnd_play(), a + frame_t'($urandom_range(0, 14)) - frame_t'(1),
                  rnd_act());
        queue_req(OpSetPlay, rnd_play(), frame_t'($urandom), rnd_act());
        repeat ($urandom_range(3, 30)) begin
          if ($urandom_range(0, 11) == 0) queue_noise();
          else queue_req(OpTick, 2'($urandom_range(0, 3)), frame_t'($urandom), rnd_act());
        end
      end else begin
        queue_noise();
      end
    end
  endtask

  initial begin
    logic [1:0] mode;
    frame_t     ts;
    frame_t     te;
    xport_state = '0;
    cfg_state   = '{loop_mode: ModeLoop, tl_start: '0, tl_end: FrameMax};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening under reset configuration
    in_idle_pct  = 25;
    out_idle_pct = 25;
    queue_req(OpSeek, PlayStop, FrameMax, ActGoIn);
    queue_req(OpAction, PlayStop, '0, ActFwd1);     // past timeline end -> start
    queue_req(OpAction, PlayStop, '0, ActBack1);    // below timeline start -> end
    queue_req(OpSeek, PlayStop, '0, ActGoIn);
    queue_req(OpSeek, PlayStop, 24'd5, ActGoIn);
    queue_req(OpInHere, PlayStop, '0, ActGoIn);
    queue_req(OpSeek, PlayStop, 24'd8, ActGoIn);
    queue_req(OpOutHere, PlayStop, '0, ActGoIn);
    queue_req(OpSetPlay, PlayFwd, '0, ActGoIn);
    repeat (4) queue_req(OpTick, PlayStop, '0, ActGoIn);
    queue_req(OpSetPlay, PlayRev, '0, ActGoIn);
    repeat (2) queue_req(OpTick, PlayStop, '0, ActGoIn);
    queue_req(OpSetPlay, PlayAlias, '0, ActGoIn);
    queue_req(OpTick, PlayStop, '0, ActGoIn);       // stopped: no change
    for (int i = 0; i < 8; i++) queue_req(OpAction, PlayStop, FrameMax, action_e'(i));
    queue_req(OpResetIn, PlayStop, '0, ActGoIn);
    queue_req(OpResetOut, PlayStop, '0, ActGoIn);
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin mode = ModeLoop;     ts = '0;         te = FrameMax; in_idle_pct = 0;
                 out_idle_pct = 30; end
        1: begin mode = ModeOnce;     ts = 24'd100;    te = 24'd140;  in_idle_pct = 20;
                 out_idle_pct = 0; end
        2: begin mode = ModePingPong; ts = 24'd100;    te = 24'd140;  in_idle_pct = 40;
                 out_idle_pct = 40; end
        3: begin mode = ModeAlias;    ts = '0;         te = 24'd30;   in_idle_pct = 10;
                 out_idle_pct = 20; end
        4: begin mode = ModePingPong; ts = '0;         te = FrameMax; in_idle_pct = 30;
                 out_idle_pct = 10; end
        5: begin mode = ModeOnce;     ts = FrameMax - 24'd15; te = FrameMax; in_idle_pct = 25;
                 out_idle_pct = 35; end
        6: begin mode = ModeLoop;     ts = 24'd50;     te = 24'd20;   in_idle_pct = 15;
                 out_idle_pct = 25; end
        7: begin mode = ModePingPong; ts = '0;         te = '0;       in_idle_pct = 35;
                 out_idle_pct = 15; end
        default: begin mode = ModeOnce; ts = 24'd1000; te = 24'd1300; in_idle_pct = 0;
                 out_idle_pct = 0; end
      endcase
      write_reg(CfgLoopMode, frame_t'(mode));
      write_reg(CfgTlStart, ts);
      write_reg(CfgTlEnd, te);
      queue_random_phase(190);
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("playback_transport_controller_top regression: pass");
    end else begin
      $display("playback_transport_controller_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/ptc_pkg.sv
sv/ptc_next.sv
sv/playback_transport_controller_top.sv
tb/tb_top.sv
